FILE: rtl/qcts_pkg.sv
package qcts_pkg;

    localparam int PORT_SLOTS = 3;
    localparam int NUM_PORTS_DEFAULT = 3;
    localparam logic [7:0] MAX_SAMPLES_RESET = 8'd4;
    localparam logic signed [7:0] SPEED_MAX = 8'sd100;
    localparam logic signed [7:0] SPEED_MIN = -8'sd100;

    localparam logic [2:0] KIND_SAMPLE    = 3'd0;
    localparam logic [2:0] KIND_TICK      = 3'd1;
    localparam logic [2:0] KIND_SET_COUNT = 3'd2;
    localparam logic [2:0] KIND_SET_SPEED = 3'd3;
    localparam logic [2:0] KIND_TARGET    = 3'd4;

    typedef struct packed {
        logic [2:0]          kind;
        logic [1:0]          port;
        logic [5:0]          pins;
        logic signed [31:0]  value;
        logic signed [7:0]   speed;
        logic                brake;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0]  count_sel;
        logic signed [7:0]   speed_sel;
        logic signed [7:0]   drive_a;
        logic signed [7:0]   drive_b;
        logic signed [7:0]   drive_c;
        logic                brake_a;
        logic                brake_b;
        logic                brake_c;
        logic                sampling_on;
    } res_t;

endpackage

FILE: rtl/quadrature_counter_target_stop.sv
// Quadrature counter with target stop for up to three motor ports. Each command beat is
// taken into an input register and then finished into a result register, so the block
// accepts one beat per clock while not stalled; it stalls its input only while a finished
// result is held back by the output stall. Pin samples count each port on a change of its
// edge bit while sampling is on, ticks restart sampling and stop ports that have reached
// a nonzero target, and the other kinds set the count, the speed or the target of one
// port. The sample limit register may only be written while no beat is in flight.
module quadrature_counter_target_stop
    import qcts_pkg::*;
#(
    parameter int NUM_PORTS = NUM_PORTS_DEFAULT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  cmd_t       cmd,
    output logic       res_valid,
    input  logic       res_stall,
    output res_t       res
);

    localparam logic [2:0] PORT_LIMIT = 3'(NUM_PORTS);

    logic [7:0]         max_samples_reg;
    logic               cmd_valid_reg;
    cmd_t               cmd_reg;
    logic               res_valid_reg;
    res_t               res_reg;
    res_t               res_next;
    logic               advance;

    logic [31:0]        pos_reg    [PORT_SLOTS];
    logic [31:0]        pos_next   [PORT_SLOTS];
    logic [31:0]        tgt_reg    [PORT_SLOTS];
    logic [31:0]        tgt_next   [PORT_SLOTS];
    logic signed [7:0]  spd_reg    [PORT_SLOTS];
    logic signed [7:0]  spd_next   [PORT_SLOTS];
    logic               edge_reg   [PORT_SLOTS];
    logic               edge_next  [PORT_SLOTS];
    logic signed [7:0]  drv_reg    [PORT_SLOTS];
    logic signed [7:0]  drv_next   [PORT_SLOTS];
    logic               brk_reg    [PORT_SLOTS];
    logic               brk_next   [PORT_SLOTS];
    logic [7:0]         samples_reg;
    logic [7:0]         samples_next;
    logic               sampling_reg;
    logic               sampling_next;
    logic               sel_ok;
    logic signed [7:0]  sat_spd;

    function automatic logic [31:0] magnitude(input logic [31:0] v);
        return v[31] ? (32'd0 - v) : v;
    endfunction

    assign advance   = cmd_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = cmd_valid_reg && !advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign sel_ok    = {1'b0, cmd_reg.port} < PORT_LIMIT;

    always_comb
    begin
        if (cmd_reg.speed > SPEED_MAX)
        begin
            sat_spd = SPEED_MAX;
        end
        else if (cmd_reg.speed < SPEED_MIN)
        begin
            sat_spd = SPEED_MIN;
        end
        else
        begin
            sat_spd = cmd_reg.speed;
        end
    end

    always_comb
    begin
        pos_next      = pos_reg;
        tgt_next      = tgt_reg;
        spd_next      = spd_reg;
        edge_next     = edge_reg;
        drv_next      = drv_reg;
        brk_next      = brk_reg;
        samples_next  = samples_reg;
        sampling_next = sampling_reg;
        if (advance)
        begin
            case (cmd_reg.kind)
                KIND_SAMPLE:
                begin
                    if (sampling_reg)
                    begin
                        if (samples_reg != 8'hFF)
                        begin
                            samples_next = samples_reg + 8'd1;
                        end
                        if (samples_next > max_samples_reg)
                        begin
                            sampling_next = 1'b0;
                        end
                        for (int p = 0; p < PORT_SLOTS; p++)
                        begin
                            if (p < NUM_PORTS && cmd_reg.pins[2*p] != edge_reg[p])
                            begin
                                if (cmd_reg.pins[2*p] != cmd_reg.pins[2*p+1])
                                begin
                                    pos_next[p] = pos_reg[p] + 32'd1;
                                end
                                else
                                begin
                                    pos_next[p] = pos_reg[p] - 32'd1;
                                end
                                edge_next[p] = cmd_reg.pins[2*p];
                            end
                        end
                    end
                end
                KIND_TICK:
                begin
                    samples_next  = 8'd0;
                    sampling_next = 1'b1;
                    for (int p = 0; p < PORT_SLOTS; p++)
                    begin
                        if (p < NUM_PORTS && spd_reg[p] != 8'sd0 && tgt_reg[p] != 32'd0 &&
                            magnitude(pos_reg[p]) >= magnitude(tgt_reg[p]))
                        begin
                            spd_next[p] = 8'sd0;
                            drv_next[p] = 8'sd0;
                            brk_next[p] = 1'b1;
                        end
                    end
                end
                KIND_SET_COUNT:
                begin
                    if (sel_ok)
                    begin
                        pos_next[cmd_reg.port] = cmd_reg.value;
                    end
                end
                KIND_SET_SPEED:
                begin
                    if (sel_ok)
                    begin
                        spd_next[cmd_reg.port] = sat_spd;
                        drv_next[cmd_reg.port] = sat_spd;
                        brk_next[cmd_reg.port] = cmd_reg.brake;
                    end
                end
                KIND_TARGET:
                begin
                    if (sel_ok)
                    begin
                        tgt_next[cmd_reg.port] = cmd_reg.value;
                        spd_next[cmd_reg.port] = sat_spd;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res_next.count_sel   = sel_ok ? pos_next[cmd_reg.port] : 32'sd0;
        res_next.speed_sel   = sel_ok ? spd_next[cmd_reg.port] : 8'sd0;
        res_next.drive_a     = drv_next[0];
        res_next.drive_b     = drv_next[1];
        res_next.drive_c     = drv_next[2];
        res_next.brake_a     = brk_next[0];
        res_next.brake_b     = brk_next[1];
        res_next.brake_c     = brk_next[2];
        res_next.sampling_on = sampling_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_samples_reg <= MAX_SAMPLES_RESET;
            cmd_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            samples_reg     <= 8'd0;
            sampling_reg    <= 1'b1;
            for (int p = 0; p < PORT_SLOTS; p++)
            begin
                pos_reg[p]  <= 32'd0;
                tgt_reg[p]  <= 32'd0;
                spd_reg[p]  <= 8'sd0;
                edge_reg[p] <= 1'b0;
                drv_reg[p]  <= 8'sd0;
                brk_reg[p]  <= 1'b0;
            end
        end
        else
        begin
            if (cfg_wen)
            begin
                max_samples_reg <= cfg_wdata;
            end
            if (!cmd_stall)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            samples_reg  <= samples_next;
            sampling_reg <= sampling_next;
            pos_reg      <= pos_next;
            tgt_reg      <= tgt_next;
            spd_reg      <= spd_next;
            edge_reg     <= edge_next;
            drv_reg      <= drv_next;
            brk_reg      <= brk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            cmd_reg <= cmd;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    // The input side is held only by a finished result that is still waiting.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (res_valid_reg && res_stall))
        else $error("input stalled without a waiting result");

    // Sampling is only ever suspended after at least one sample beat in the period.
    a_suspend_count: assert property (@(posedge clk) disable iff (!rst_n)
        !sampling_reg |-> (samples_reg != 8'd0))
        else $error("sampling suspended with an empty period");

    // The brake of port A is only applied by a tick or a speed command.
    a_brake_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!brk_reg[0] && brk_next[0]) |->
            (advance && (cmd_reg.kind == KIND_TICK || cmd_reg.kind == KIND_SET_SPEED)))
        else $error("brake applied by an unexpected beat");

endmodule

FILE: test/quadrature_counter_target_stop_tb.sv
module quadrature_counter_target_stop_tb;

    import qcts_pkg::*;

    localparam int NUM_MOTORS = NUM_PORTS_DEFAULT;

    localparam logic [1:0] PORT_A    = 2'd0;
    localparam logic [1:0] PORT_B    = 2'd1;
    localparam logic [1:0] PORT_C    = 2'd2;
    localparam logic [1:0] PORT_NONE = 2'd3;

    localparam logic [2:0] KIND_SPARE_LO = 3'd5;
    localparam logic [2:0] KIND_SPARE_HI = 3'd7;

    typedef struct {
        cmd_t c;
        bit   typed;
        res_t want;
    } beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wen = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    cmd_t       cmd = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    res_t       res;

    beat_t beats_waiting[$];
    res_t  status_due[$];
    beat_t on_bus;
    bit    cmd_fired = 1'b0;
    int    idle_pct = 30;
    int    stall_pct = 30;
    int    mismatches = 0;
    res_t  oldest;
    res_t  predicted;

    logic [31:0]       pos_q   [NUM_MOTORS] = '{default: '0};
    logic [31:0]       tgt_q   [NUM_MOTORS] = '{default: '0};
    logic signed [7:0] spd_q   [NUM_MOTORS] = '{default: '0};
    logic              edge_q  [NUM_MOTORS] = '{default: 1'b0};
    logic signed [7:0] drv_q   [NUM_MOTORS] = '{default: '0};
    logic              brk_q   [NUM_MOTORS] = '{default: 1'b0};
    logic [7:0]        period_samples = 8'd0;
    logic              sampling_q = 1'b1;
    logic [7:0]        sample_limit = MAX_SAMPLES_RESET;

    quadrature_counter_target_stop u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    always #5 clk = ~clk;

    function automatic logic signed [7:0] clamp_pct(logic signed [7:0] s);
        if (s > SPEED_MAX)
        begin
            return SPEED_MAX;
        end
        if (s < SPEED_MIN)
        begin
            return SPEED_MIN;
        end
        return s;
    endfunction

    function automatic logic [31:0] abs_count(logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    function res_t advance_motors(cmd_t c);
        res_t r;
        r = '0;
        case (c.kind)
            KIND_SAMPLE:
            begin
                if (sampling_q)
                begin
                    if (period_samples != 8'd255)
                    begin
                        period_samples = period_samples + 8'd1;
                    end
                    if (period_samples > sample_limit)
                    begin
                        sampling_q = 1'b0;
                    end
                    for (int i = 0; i < NUM_MOTORS; i++)
                    begin
                        if (c.pins[2*i] != edge_q[i])
                        begin
                            if (c.pins[2*i] != c.pins[2*i+1])
                            begin
                                pos_q[i] = pos_q[i] + 32'd1;
                            end
                            else
                            begin
                                pos_q[i] = pos_q[i] - 32'd1;
                            end
                            edge_q[i] = c.pins[2*i];
                        end
                    end
                end
            end
            KIND_TICK:
            begin
                period_samples = 8'd0;
                sampling_q = 1'b1;
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    if (spd_q[i] != 0 && tgt_q[i] != 0 &&
                        abs_count(pos_q[i]) >= abs_count(tgt_q[i]))
                    begin
                        spd_q[i] = '0;
                        drv_q[i] = '0;
                        brk_q[i] = 1'b1;
                    end
                end
            end
            KIND_SET_COUNT:
            begin
                if (c.port < NUM_MOTORS)
                begin
                    pos_q[c.port] = c.value;
                end
            end
            KIND_SET_SPEED:
            begin
                if (c.port < NUM_MOTORS)
                begin
                    spd_q[c.port] = clamp_pct(c.speed);
                    drv_q[c.port] = clamp_pct(c.speed);
                    brk_q[c.port] = c.brake;
                end
            end
            KIND_TARGET:
            begin
                if (c.port < NUM_MOTORS)
                begin
                    tgt_q[c.port] = c.value;
                    spd_q[c.port] = clamp_pct(c.speed);
                end
            end
            default:
            begin
            end
        endcase
        if (c.port < NUM_MOTORS)
        begin
            r.count_sel = pos_q[c.port];
            r.speed_sel = spd_q[c.port];
        end
        r.drive_a = drv_q[PORT_A];
        r.drive_b = drv_q[PORT_B];
        r.drive_c = drv_q[PORT_C];
        r.brake_a = brk_q[PORT_A];
        r.brake_b = brk_q[PORT_B];
        r.brake_c = brk_q[PORT_C];
        r.sampling_on = sampling_q;
        return r;
    endfunction

    function automatic cmd_t make_cmd(logic [2:0] k, logic [1:0] p, logic [5:0] pins,
                                      logic [31:0] v, logic [7:0] s, logic b);
        cmd_t c;
        c.kind = k;
        c.port = p;
        c.pins = pins;
        c.value = v;
        c.speed = s;
        c.brake = b;
        return c;
    endfunction

    function automatic res_t status(logic [31:0] cnt, logic [7:0] s, logic [7:0] da,
                                    logic [7:0] db, logic [7:0] dc, logic ba, logic bb,
                                    logic bc, logic on);
        res_t r;
        r.count_sel = cnt;
        r.speed_sel = s;
        r.drive_a = da;
        r.drive_b = db;
        r.drive_c = dc;
        r.brake_a = ba;
        r.brake_b = bb;
        r.brake_c = bc;
        r.sampling_on = on;
        return r;
    endfunction

    function automatic beat_t plain(cmd_t c);
        beat_t b;
        b.c = c;
        b.typed = 1'b0;
        b.want = '0;
        return b;
    endfunction

    function automatic beat_t typed(cmd_t c, res_t r);
        beat_t b;
        b.c = c;
        b.typed = 1'b1;
        b.want = r;
        return b;
    endfunction

    function automatic cmd_t random_cmd();
        cmd_t c;
        int   sel;
        sel = $urandom_range(99);
        if (sel < 42)
            c.kind = KIND_SAMPLE;
        else if (sel < 54)
            c.kind = KIND_TICK;
        else if (sel < 64)
            c.kind = KIND_SET_COUNT;
        else if (sel < 78)
            c.kind = KIND_SET_SPEED;
        else if (sel < 94)
            c.kind = KIND_TARGET;
        else
            c.kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
        c.port = ($urandom_range(19) == 0) ? PORT_NONE : 2'($urandom_range(PORT_C, PORT_A));
        c.pins = 6'($urandom);
        sel = $urandom_range(9);
        if (sel < 6)
            c.value = 32'($signed($urandom_range(48)) - 24);
        else if (sel < 8)
            c.value = $urandom;
        else if (sel == 8)
            c.value = ($urandom_range(1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            c.value = '0;
        if ($urandom_range(3) == 0)
            c.speed = 8'($urandom);
        else
            c.speed = 8'($signed($urandom_range(200)) - 100);
        c.brake = 1'($urandom_range(1));
        return c;
    endfunction

    function void check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // A new beat is offered only once the previous one has been taken.
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_fired))
        begin
            if (beats_waiting.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                on_bus = beats_waiting.pop_front();
                cmd <= on_bus.c;
                cmd_valid <= 1'b1;
            end
            else
            begin
                cmd_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cmd_fired = cmd_valid && !cmd_stall;
            if (cmd_fired)
            begin
                predicted = advance_motors(cmd);
                status_due.push_back(on_bus.typed ? on_bus.want : predicted);
            end
            if (res_valid && !res_stall)
            begin
                if (status_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got %p", $time, res);
                    mismatches++;
                end
                else
                begin
                    oldest = status_due.pop_front();
                    check_field("count_sel", oldest.count_sel, res.count_sel);
                    check_field("speed_sel", oldest.speed_sel, res.speed_sel);
                    check_field("drive_a", oldest.drive_a, res.drive_a);
                    check_field("drive_b", oldest.drive_b, res.drive_b);
                    check_field("drive_c", oldest.drive_c, res.drive_c);
                    check_field("brake_a", oldest.brake_a, res.brake_a);
                    check_field("brake_b", oldest.brake_b, res.brake_b);
                    check_field("brake_c", oldest.brake_c, res.brake_c);
                    check_field("sampling_on", oldest.sampling_on, res.sampling_on);
                end
            end
        end
    end

    task drain();
        while (beats_waiting.size() != 0 || cmd_valid || status_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task write_sample_limit(input logic [7:0] v);
        @(negedge clk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sample_limit = v;
    endtask

    initial
    begin
        beat_t      script[$];
        logic [7:0] limits[5];

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        script.push_back(typed(make_cmd(KIND_TICK, PORT_A, 6'h00, 32'h0, 8'h00, 1'b0),
                               status(32'h0, 8'sd0, 8'sd0, 8'sd0, 8'sd0,
                                      1'b0, 1'b0, 1'b0, 1'b1)));
        script.push_back(typed(make_cmd(KIND_SET_SPEED, PORT_A, 6'h00, 32'h0, 8'h7F, 1'b1),
                               status(32'h0, 8'sd100, 8'sd100, 8'sd0, 8'sd0,
                                      1'b1, 1'b0, 1'b0, 1'b1)));
        script.push_back(typed(make_cmd(KIND_SET_SPEED, PORT_B, 6'h00, 32'h0, 8'h80, 1'b0),
                               status(32'h0, -8'sd100, 8'sd100, -8'sd100, 8'sd0,
                                      1'b1, 1'b0, 1'b0, 1'b1)));
        script.push_back(typed(make_cmd(KIND_SET_SPEED, PORT_NONE, 6'h3F, 32'hFFFF_FFFF,
                                        8'h05, 1'b1),
                               status(32'h0, 8'sd0, 8'sd100, -8'sd100, 8'sd0,
                                      1'b1, 1'b0, 1'b0, 1'b1)));
        script.push_back(typed(make_cmd(KIND_SET_COUNT, PORT_C, 6'h00, 32'h8000_0000,
                                        8'h00, 1'b0),
                               status(32'h8000_0000, 8'sd0, 8'sd100, -8'sd100, 8'sd0,
                                      1'b1, 1'b0, 1'b0, 1'b1)));
        script.push_back(plain(make_cmd(KIND_TARGET, PORT_C, 6'h00, 32'h7FFF_FFFF, 8'd50, 1'b0)));
        script.push_back(plain(make_cmd(KIND_TICK, PORT_C, 6'h00, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SPARE_LO, PORT_A, 6'h00, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SPARE_HI, PORT_NONE, 6'h3F, 32'hFFFF_FFFF,
                                        8'hFF, 1'b1)));
        script.push_back(plain(make_cmd(KIND_SET_COUNT, PORT_A, 6'h00, 32'h7FFF_FFFF,
                                        8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_A, 6'b010101, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_B, 6'b111111, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_C, 6'b101010, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_A, 6'b000000, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_B, 6'b111111, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SAMPLE, PORT_C, 6'b000000, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_TICK, PORT_B, 6'h00, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_TARGET, PORT_B, 6'h00, 32'h8000_0000,
                                        8'sd100, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SET_SPEED, PORT_C, 6'h00, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_SET_COUNT, PORT_B, 6'h00, 32'h0, 8'h00, 1'b0)));
        script.push_back(plain(make_cmd(KIND_TICK, PORT_B, 6'h00, 32'h0, 8'h00, 1'b0)));

        foreach (script[i])
        begin
            beats_waiting.push_back(script[i]);
        end
        drain();

        limits = '{8'd0, 8'd255, 8'd1, 8'($urandom_range(254, 2)), MAX_SAMPLES_RESET};
        for (int ph = 0; ph < 5; ph++)
        begin
            write_sample_limit(limits[ph]);
            // One whole phase runs with no gaps on either side.
            idle_pct = (ph == 3) ? 0 : 30;
            stall_pct = (ph == 3) ? 0 : 30;
            if (limits[ph] == 8'd255)
            begin
                repeat (270)
                begin
                    beats_waiting.push_back(plain(make_cmd(KIND_SAMPLE,
                                                           2'($urandom_range(PORT_C, PORT_A)),
                                                           6'($urandom), $urandom,
                                                           8'($urandom), 1'($urandom))));
                end
            end
            repeat (200)
            begin
                beats_waiting.push_back(plain(random_cmd()));
            end
            drain();
        end

        if (mismatches == 0)
        begin
            $display("PASS quadrature_counter_target_stop");
        end
        else
        begin
            $display("FAIL quadrature_counter_target_stop");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAIL quadrature_counter_target_stop");
        $finish;
    end

endmodule
